// ===== hdl/line_track_marker_sequencer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the line-track marker sequencer
// Checks are compiled for simulation only; synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef LINE_TRACK_MARKER_SEQUENCER_CORE_MACROS_SVH
`define LINE_TRACK_MARKER_SEQUENCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define LMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lms assertion failed");
// next-cycle implication, checked out of reset
`define LMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lms assertion failed");
`else
`define LMS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/lms_pkg.sv =====
// ----------------------------------------------------------------------------
// lms_pkg
// Types and constants shared by the line-track marker sequencer.
// ----------------------------------------------------------------------------
package lms_pkg;

    localparam logic [7:0]  MASK_LEFT          = 8'h06;
    localparam logic [7:0]  MASK_RIGHT         = 8'h60;
    localparam logic [7:0]  MASK_CENTER        = 8'h18;
    localparam logic [15:0] STRAIGHT_TICKS_RST = 16'd30;
    localparam logic [7:0]  CONFIRM_TICKS_RST  = 8'd1;

    localparam logic REG_STRAIGHT_TICKS = 1'b0;
    localparam logic REG_CONFIRM_TICKS  = 1'b1;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_STRAIGHT = 2'd1,
        MODE_TLEFT    = 2'd2,
        MODE_TRIGHT   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } t_side;

    typedef enum logic [1:0] {
        DRIVE_LINE     = 2'd0,
        DRIVE_LOST     = 2'd1,
        DRIVE_STRAIGHT = 2'd2,
        DRIVE_YAW      = 2'd3
    } t_drive;

    typedef struct packed {
        t_mode       mode;
        t_side       side;
        logic        armed;
        t_side       cand;
        logic [7:0]  confirm_cnt;
        logic [15:0] straight_cnt;
        logic [1:0]  turn_cnt;
    } t_state;

    typedef struct packed {
        logic [15:0] straight_ticks;
        logic [7:0]  confirm_ticks;
    } t_cfg;

    typedef struct packed {
        t_drive drive_mode;
        t_mode  mode_state;
        t_side  marker_side;
        logic   reset_loops;
        logic   begin_turn;
        logic   stop_motor;
    } t_result;

endpackage

// ===== hdl/lms_in_if.sv =====
// ----------------------------------------------------------------------------
// lms_in_if
// Sensor pattern channel, one item per control tick.
// ----------------------------------------------------------------------------
interface lms_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] gray_pattern;

    modport source (output valid, output gray_pattern, input ready);
    modport sink   (input valid, input gray_pattern, output ready);
endinterface

// ===== hdl/lms_out_if.sv =====
// ----------------------------------------------------------------------------
// lms_out_if
// Result channel: drive mode, state, side and one-tick flags.
// ----------------------------------------------------------------------------
interface lms_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] drive_mode;
    logic [1:0] mode_state;
    logic [1:0] marker_side;
    logic       reset_loops;
    logic       begin_turn;
    logic       stop_motor;

    modport source (output valid, output drive_mode, output mode_state,
                    output marker_side, output reset_loops, output begin_turn,
                    output stop_motor, input ready);
    modport sink   (input valid, input drive_mode, input mode_state,
                    input marker_side, input reset_loops, input begin_turn,
                    input stop_motor, output ready);
endinterface

// ===== hdl/lms_step.sv =====
// ----------------------------------------------------------------------------
// lms_step
// Mode machine update for one sensor pattern: next state and result item.
// ----------------------------------------------------------------------------
module lms_step (
    input  lms_pkg::t_state  i_state,
    input  logic [7:0]       i_gray,
    input  lms_pkg::t_cfg    i_cfg,
    output lms_pkg::t_state  o_state,
    output lms_pkg::t_result o_result
);

    logic          w_armed;
    lms_pkg::t_side w_seen;
    logic [7:0]    w_cc;
    logic          w_confirm;
    logic [15:0]   w_sc;
    logic          w_straight_done;
    logic [1:0]    w_tc;
    logic          w_turn_done;

    // normal mode: marker detection and confirmation
    assign w_armed = i_state.armed | ((i_gray & (lms_pkg::MASK_LEFT | lms_pkg::MASK_RIGHT)) == 8'd0);
    assign w_seen  = (i_gray == lms_pkg::MASK_LEFT)  ? lms_pkg::SIDE_LEFT  :
                     (i_gray == lms_pkg::MASK_RIGHT) ? lms_pkg::SIDE_RIGHT : lms_pkg::SIDE_NONE;
    assign w_cc    = (i_state.confirm_cnt < i_cfg.confirm_ticks) ?
                     8'(i_state.confirm_cnt + 8'd1) : i_state.confirm_cnt;
    assign w_confirm = w_armed && (w_seen != lms_pkg::SIDE_NONE) && (w_seen == i_state.cand)
                       && (w_cc >= i_cfg.confirm_ticks);

    // straight run and turn counters
    assign w_sc            = 16'(i_state.straight_cnt + 16'd1);
    assign w_straight_done = (w_sc >= i_cfg.straight_ticks);
    assign w_tc            = (i_state.turn_cnt < 2'd2) ? 2'(i_state.turn_cnt + 2'd1)
                                                       : i_state.turn_cnt;
    assign w_turn_done     = (w_tc > 2'd1) && ((i_gray & lms_pkg::MASK_CENTER) != 8'd0);

    // next state
    always_comb begin
        o_state = i_state;
        unique case (i_state.mode)
            lms_pkg::MODE_STRAIGHT: begin
                if (w_straight_done) begin
                    o_state.straight_cnt = 16'd0;
                    o_state.turn_cnt     = 2'd0;
                    o_state.mode = (i_state.side == lms_pkg::SIDE_LEFT) ?
                                   lms_pkg::MODE_TLEFT : lms_pkg::MODE_TRIGHT;
                end else begin
                    o_state.straight_cnt = w_sc;
                end
            end
            lms_pkg::MODE_TLEFT, lms_pkg::MODE_TRIGHT: begin
                o_state.turn_cnt = w_tc;
                if (w_turn_done) begin
                    o_state.mode = lms_pkg::MODE_NORMAL;
                    o_state.side = lms_pkg::SIDE_NONE;
                end
            end
            default: begin
                o_state.armed = w_armed;
                if (!w_armed || w_seen == lms_pkg::SIDE_NONE || w_confirm) begin
                    o_state.cand        = lms_pkg::SIDE_NONE;
                    o_state.confirm_cnt = 8'd0;
                end else if (w_seen != i_state.cand) begin
                    o_state.cand        = w_seen;
                    o_state.confirm_cnt = 8'd1;
                end else begin
                    o_state.confirm_cnt = w_cc;
                end
                if (w_confirm) begin
                    o_state.side         = w_seen;
                    o_state.armed        = 1'b0;
                    o_state.straight_cnt = 16'd0;
                    o_state.mode         = lms_pkg::MODE_STRAIGHT;
                end
            end
        endcase
    end

    // result item
    always_comb begin
        o_result.mode_state  = o_state.mode;
        o_result.marker_side = o_state.side;
        o_result.reset_loops = 1'b0;
        o_result.begin_turn  = 1'b0;
        o_result.stop_motor  = 1'b0;
        unique case (i_state.mode)
            lms_pkg::MODE_STRAIGHT: begin
                o_result.drive_mode  = lms_pkg::DRIVE_STRAIGHT;
                o_result.reset_loops = w_straight_done;
                o_result.begin_turn  = w_straight_done;
            end
            lms_pkg::MODE_TLEFT, lms_pkg::MODE_TRIGHT: begin
                o_result.drive_mode  = lms_pkg::DRIVE_YAW;
                o_result.reset_loops = w_turn_done;
                o_result.stop_motor  = w_turn_done;
            end
            default: begin
                o_result.reset_loops = w_confirm;
                if (w_confirm) begin
                    o_result.drive_mode = lms_pkg::DRIVE_STRAIGHT;
                end else if (i_gray == 8'd0) begin
                    o_result.drive_mode = lms_pkg::DRIVE_LOST;
                end else begin
                    o_result.drive_mode = lms_pkg::DRIVE_LINE;
                end
            end
        endcase
    end

endmodule

// ===== hdl/line_track_marker_sequencer_core.sv =====
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while the result side is ready; the input
// register feeds the mode logic and the result register, which moves on when free.
// Reset (synchronous, active low): normal mode, armed, counters cleared,
// straight_ticks 30, confirm_ticks 1, both pipeline registers empty.
// ----------------------------------------------------------------------------
// line_track_marker_sequencer_core
// Marker confirmation, straight run and yaw turn sequencing per sensor tick.
// ----------------------------------------------------------------------------
`include "line_track_marker_sequencer_core_macros.svh"

module line_track_marker_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lms_in_if.sink      i_in_ch,
    lms_out_if.source   o_out_ch,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    lms_pkg::t_cfg    r_cfg;
    lms_pkg::t_state  r_state, n_state;
    lms_pkg::t_result r_out, n_out;
    logic             r_in_valid;
    logic [7:0]       r_gray;
    logic             r_out_valid;
    logic             w_move;

    // advance the input item into the result register when it is free
    assign w_move         = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready  = !r_in_valid || w_move;

    lms_step u_step (
        .i_state  (r_state),
        .i_gray   (r_gray),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.straight_ticks <= lms_pkg::STRAIGHT_TICKS_RST;
            r_cfg.confirm_ticks  <= lms_pkg::CONFIRM_TICKS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == lms_pkg::REG_STRAIGHT_TICKS) begin
                r_cfg.straight_ticks <= i_cfg_data;
            end else begin
                r_cfg.confirm_ticks <= i_cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: lms_pkg::MODE_NORMAL, side: lms_pkg::SIDE_NONE, armed: 1'b1,
                         cand: lms_pkg::SIDE_NONE, confirm_cnt: 8'd0,
                         straight_cnt: 16'd0, turn_cnt: 2'd0};
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_gray <= i_in_ch.gray_pattern;
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.drive_mode  = r_out.drive_mode;
    assign o_out_ch.mode_state  = r_out.mode_state;
    assign o_out_ch.marker_side = r_out.marker_side;
    assign o_out_ch.reset_loops = r_out.reset_loops;
    assign o_out_ch.begin_turn  = r_out.begin_turn;
    assign o_out_ch.stop_motor  = r_out.stop_motor;

    `LMS_ASSERT_NOW(a_begin_in_turn, i_clk, i_rst_n, r_out_valid && r_out.begin_turn, r_out.mode_state == lms_pkg::MODE_TLEFT || r_out.mode_state == lms_pkg::MODE_TRIGHT)
    `LMS_ASSERT_NOW(a_stop_clears, i_clk, i_rst_n, r_out_valid && r_out.stop_motor, r_out.mode_state == lms_pkg::MODE_NORMAL && r_out.marker_side == lms_pkg::SIDE_NONE)
    `LMS_ASSERT_NOW(a_straight_side, i_clk, i_rst_n, r_state.mode == lms_pkg::MODE_STRAIGHT, r_state.side != lms_pkg::SIDE_NONE)
    `LMS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !i_in_ch.ready, r_in_valid && r_out_valid && !o_out_ch.ready)
    `LMS_ASSERT_NEXT(a_move_fills, i_clk, i_rst_n, w_move, r_out_valid)

endmodule
